FILE: sv/qpd_pkg.sv
// Shared types, constants and helpers for the query parameter extractor.
// Used by every module of the block; depends on nothing else.
package qpd_pkg;

  localparam int MAX_KEY_CHARS = 8;
  localparam int KEY_POS_W     = $clog2(MAX_KEY_CHARS + 1);
  localparam int KEY_SEL_W     = $clog2(MAX_KEY_CHARS);
  localparam int MAX_RESULTS   = 4;
  localparam int RES_IDX_W     = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_AMP     = 8'h26;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_EQUALS  = 8'h3D;

  localparam logic [KEY_POS_W-1:0] KEY_LENGTH_RST     = KEY_POS_W'(1);
  localparam logic [7:0]           VALUE_CAPACITY_RST = 8'd32;

  typedef enum logic [3:0] {
    PH_MATCH = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HEX  = 3'b100
  } esc_e;

  typedef enum logic [1:0] {
    CFG_KEY_TEXT       = 2'd0,
    CFG_KEY_LENGTH     = 2'd1,
    CFG_VALUE_CAPACITY = 2'd2
  } cfg_index_e;

  typedef struct packed {
    phase_e                phase;
    logic [KEY_POS_W-1:0]  key_position;
    logic [7:0]            raw_count;
    esc_e                  escape_stage;
    logic [7:0]            first_hex_char;
    logic                  match_seen;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:          PH_MATCH,
    key_position:   '0,
    raw_count:      '0,
    escape_stage:   ESC_NONE,
    first_hex_char: '0,
    match_seen:     1'b0
  };

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       found;
    logic       last;
  } result_t;

  typedef result_t [MAX_RESULTS-1:0] result_vec_t;

  // Effective configuration as seen by the scan logic.
  typedef struct packed {
    logic [63:0]          key_text;
    logic [KEY_POS_W-1:0] key_len;
    logic [7:0]           limit;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // ASCII hex digit of either case.
  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid = 1'b1;
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.valid = 1'b1;
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.valid = 1'b1;
      h.value = 4'(c - 8'h37);
    end
    return h;
  endfunction

endpackage

FILE: sv/qpd_cfg_regs.sv
// Configuration registers of the query parameter extractor.
// Depends on qpd_pkg; presents clamped key length and raw byte limit.
module qpd_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output qpd_pkg::cfg_t      cfg_o
);
  import qpd_pkg::*;

  logic [63:0]          key_text_q, key_text_d;
  logic [3:0]           key_length_q, key_length_d;
  logic [7:0]           capacity_q, capacity_d;

  always_comb begin
    key_text_d   = key_text_q;
    key_length_d = key_length_q;
    capacity_d   = capacity_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_KEY_TEXT:       key_text_d   = cfg_data_i;
        CFG_KEY_LENGTH:     key_length_d = cfg_data_i[3:0];
        CFG_VALUE_CAPACITY: capacity_d   = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_text_q   <= '0;
      key_length_q <= 4'(KEY_LENGTH_RST);
      capacity_q   <= VALUE_CAPACITY_RST;
    end else begin
      key_text_q   <= key_text_d;
      key_length_q <= key_length_d;
      capacity_q   <= capacity_d;
    end
  end

  // Clamp key length into 1..MAX_KEY_CHARS; limit is capacity minus one.
  always_comb begin
    cfg_o.key_text = key_text_q;
    if (key_length_q == 4'd0) begin
      cfg_o.key_len = KEY_POS_W'(1);
    end else if (32'(key_length_q) > MAX_KEY_CHARS) begin
      cfg_o.key_len = KEY_POS_W'(MAX_KEY_CHARS);
    end else begin
      cfg_o.key_len = KEY_POS_W'(key_length_q);
    end
    cfg_o.limit = (capacity_q == 8'd0) ? 8'd0 : capacity_q - 8'd1;
  end

endmodule

FILE: sv/qpd_step.sv
// Per-item scan and percent-decode logic of the query parameter extractor.
// Depends on qpd_pkg; purely combinational, up to four results per item.
module qpd_step (
  input  qpd_pkg::scan_state_t              cur_i,
  input  qpd_pkg::cfg_t                     cfg_i,
  input  logic [7:0]                        query_byte_i,
  input  logic                              has_byte_i,
  input  logic                              end_of_query_i,
  output qpd_pkg::scan_state_t              nxt_o,
  output qpd_pkg::result_vec_t              res_o,
  output logic [qpd_pkg::RES_CNT_W-1:0]     cnt_o
);
  import qpd_pkg::*;

  hex_t                 hc, hf;
  logic [7:0]           kc;
  logic [7:0]           dec;
  logic                 take, zero_end, flush_now;
  scan_state_t          nxt;
  result_vec_t          res;
  logic [RES_CNT_W-1:0] n;

  assign hc  = hex_decode(query_byte_i);
  assign hf  = hex_decode(cur_i.first_hex_char);
  assign kc  = cfg_i.key_text[{cur_i.key_position[KEY_SEL_W-1:0], 3'b000} +: 8];
  assign dec = {hf.value, hc.value};

  function automatic result_t char_result(logic [7:0] ch);
    return '{value_byte: ch, byte_valid: 1'b1, found: 1'b1, last: 1'b0};
  endfunction

  always_comb begin
    nxt       = cur_i;
    res       = '0;
    n         = '0;
    take      = 1'b1;
    zero_end  = 1'b0;
    flush_now = 1'b0;

    if (has_byte_i) begin
      if (query_byte_i == CHAR_NUL) begin
        flush_now = (cur_i.phase == PH_VALUE);
        nxt.phase = PH_DONE;
      end else if (cur_i.phase == PH_MATCH) begin
        if (query_byte_i == CHAR_AMP) begin
          nxt.key_position = '0;
        end else if (cur_i.key_position < cfg_i.key_len) begin
          if (query_byte_i == kc) nxt.key_position = cur_i.key_position + KEY_POS_W'(1);
          else                    nxt.phase = PH_SKIP;
        end else if (query_byte_i == CHAR_EQUALS) begin
          nxt.match_seen   = 1'b1;
          nxt.raw_count    = '0;
          nxt.escape_stage = ESC_NONE;
          nxt.phase        = (cfg_i.limit == 8'd0) ? PH_DONE : PH_VALUE;
        end else begin
          nxt.phase = PH_SKIP;
        end
      end else if (cur_i.phase == PH_SKIP) begin
        if (query_byte_i == CHAR_AMP) begin
          nxt.phase        = PH_MATCH;
          nxt.key_position = '0;
        end
      end else if (cur_i.phase == PH_VALUE) begin
        if (query_byte_i == CHAR_AMP) begin
          flush_now = 1'b1;
          nxt.phase = PH_DONE;
        end else begin
          nxt.raw_count = cur_i.raw_count + 8'd1;
          if (cur_i.escape_stage == ESC_PCT) begin
            if (hc.valid) begin
              nxt.first_hex_char = query_byte_i;
              nxt.escape_stage   = ESC_HEX;
              take               = 1'b0;
            end else begin
              res[n[RES_IDX_W-1:0]] = char_result(CHAR_PERCENT);
              n                     = n + RES_CNT_W'(1);
              nxt.escape_stage      = ESC_NONE;
            end
          end else if (cur_i.escape_stage == ESC_HEX) begin
            if (hf.valid && hc.valid) begin
              nxt.escape_stage = ESC_NONE;
              take             = 1'b0;
              if (dec == CHAR_NUL) begin
                zero_end = 1'b1;
              end else begin
                res[n[RES_IDX_W-1:0]] = char_result(dec);
                n                     = n + RES_CNT_W'(1);
              end
            end else begin
              res[n[RES_IDX_W-1:0]] = char_result(CHAR_PERCENT);
              n                     = n + RES_CNT_W'(1);
              res[n[RES_IDX_W-1:0]] = char_result(cur_i.first_hex_char);
              n                     = n + RES_CNT_W'(1);
              nxt.escape_stage      = ESC_NONE;
            end
          end
          if (take) begin
            if (query_byte_i == CHAR_PERCENT) begin
              nxt.escape_stage = ESC_PCT;
            end else if (query_byte_i == CHAR_PLUS) begin
              res[n[RES_IDX_W-1:0]] = char_result(CHAR_SPACE);
              n                     = n + RES_CNT_W'(1);
            end else begin
              res[n[RES_IDX_W-1:0]] = char_result(query_byte_i);
              n                     = n + RES_CNT_W'(1);
            end
          end
          if (zero_end) begin
            nxt.phase = PH_DONE;
          end else if (nxt.raw_count >= cfg_i.limit) begin
            flush_now = 1'b1;
            nxt.phase = PH_DONE;
          end
        end
      end
    end

    // At most one flush per item: a byte that ends the value leaves PH_VALUE.
    if (end_of_query_i && nxt.phase == PH_VALUE) flush_now = 1'b1;

    if (flush_now) begin
      if (nxt.escape_stage == ESC_PCT) begin
        res[n[RES_IDX_W-1:0]] = char_result(CHAR_PERCENT);
        n                     = n + RES_CNT_W'(1);
      end else if (nxt.escape_stage == ESC_HEX) begin
        res[n[RES_IDX_W-1:0]] = char_result(CHAR_PERCENT);
        n                     = n + RES_CNT_W'(1);
        res[n[RES_IDX_W-1:0]] = char_result(nxt.first_hex_char);
        n                     = n + RES_CNT_W'(1);
      end
      nxt.escape_stage = ESC_NONE;
    end

    if (end_of_query_i) begin
      res[n[RES_IDX_W-1:0]] = '{value_byte: CHAR_NUL, byte_valid: 1'b0,
                                found: nxt.match_seen, last: 1'b1};
      n                     = n + RES_CNT_W'(1);
      nxt                   = SCAN_RESET;
    end

    nxt_o = nxt;
    res_o = res;
    cnt_o = n;
  end

endmodule

FILE: sv/qpd_out_buf.sv
// Result buffer of the query parameter extractor: holds one item's results.
// Depends on qpd_pkg; drains one result per cycle while the output is ready.
module qpd_out_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  qpd_pkg::result_vec_t          res_i,
  input  logic [qpd_pkg::RES_CNT_W-1:0] cnt_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output qpd_pkg::result_t              out_o,
  output logic                          can_load_o
);
  import qpd_pkg::*;

  result_vec_t          entries_q;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic [RES_IDX_W-1:0] rd_q, rd_d;

  assign out_valid_o = (cnt_q != '0);
  assign out_o       = entries_q[rd_q];
  // Take a new item when empty or when the last result leaves this cycle.
  assign can_load_o  = (cnt_q == '0) || (cnt_q == RES_CNT_W'(1) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = cnt_i;
      rd_d  = '0;
    end else if (out_valid_o && out_ready_i) begin
      cnt_d = cnt_q - RES_CNT_W'(1);
      rd_d  = rd_q + RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) entries_q <= res_i;
  end

endmodule

FILE: sv/query_param_extract_decode.sv
// Top level of the query parameter extractor with percent decoding.
// Depends on qpd_pkg, qpd_cfg_regs, qpd_step and qpd_out_buf.

// Feed a URL query string one byte per input item; the block finds the first
// '&'-separated segment that starts with the configured key and '=', and
// streams the percent-decoded value (%HH to a byte, '+' to a space) as result
// items, closed by one result with last set that reports whether the key was
// found. Each item is scanned in the cycle it is accepted and its results
// (at most four) land in a four-entry result buffer that drains one result
// per cycle while the output is ready. An item that yields zero or one result
// can follow in the next cycle with the output ready; an item that yields more
// keeps the input waiting until its last result leaves the single-port buffer.
// Configuration writes are taken in any cycle but belong in idle periods;
// register index 3 is ignored.
module query_param_extract_decode (
  input  logic        clk_i,
  input  logic        rst_ni,
  // query byte items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  query_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_query_i,
  // decoded value results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  value_byte_o,
  output logic        byte_valid_o,
  output logic        found_o,
  output logic        last_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import qpd_pkg::*;

  cfg_t                 cfg;
  scan_state_t          state_q, state_d;
  result_vec_t          step_res;
  logic [RES_CNT_W-1:0] step_cnt;
  result_t              out_res;
  logic                 in_acc;

  // Registers never stall a write.
  assign cfg_ready_o = 1'b1;

  qpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Scan the accepted byte against the current state in one pass.
  qpd_step u_step (
    .cur_i          (state_q),
    .cfg_i          (cfg),
    .query_byte_i   (query_byte_i),
    .has_byte_i     (has_byte_i),
    .end_of_query_i (end_of_query_i),
    .nxt_o          (state_d),
    .res_o          (step_res),
    .cnt_o          (step_cnt)
  );

  assign in_acc = in_valid_i && in_ready_o;

  // Advance the scan state only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCAN_RESET;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Hold the item's results and hand them out one per cycle while the output is ready.
  qpd_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_acc),
    .res_i       (step_res),
    .cnt_i       (step_cnt),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_res),
    .can_load_o  (in_ready_o)
  );

  assign value_byte_o = out_res.value_byte;
  assign byte_valid_o = out_res.byte_valid;
  assign found_o      = out_res.found;
  assign last_o       = out_res.last;

  // A closing result carries no character.
  a_last_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !byte_valid_o && value_byte_o == CHAR_NUL)
    else $error("closing result carries a character");

  // A value character only appears once the key has matched.
  a_byte_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> found_o && !last_o)
    else $error("value character without a key match");

  // End of query always yields a result and restarts the scan.
  a_eoq_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_query_i |-> step_cnt != '0)
    else $error("end of query produced no closing result");

  a_eoq_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_query_i |=> state_q.phase == PH_MATCH && !state_q.match_seen)
    else $error("scan state not cleared after end of query");

  // One item never yields more results than the buffer holds.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> 32'(step_cnt) <= MAX_RESULTS)
    else $error("too many results for one item");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for query_param_extract_decode: drives query strings
// through the item channel and checks every decoded value result on the fly.
// Depends on qpd_pkg and the RTL of the block; reads no files.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qpd_pkg::*;

  localparam int unsigned LONG_HOLD      = 160;   // receiver hold-off, cycles
  localparam int unsigned SETTLE_CYCLES  = 8;     // quiet time before config or end
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned PHASE_ITEMS    = 30;

  // Predict the decoded value stream and hold the results still to come.
  class query_value_checker;
    logic [63:0] key_text;
    logic [3:0]  key_length;
    logic [7:0]  capacity;
    phase_e      phase;
    int unsigned key_pos;
    logic [7:0]  raw_count;
    esc_e        esc;
    logic [7:0]  hex_hi;
    bit          key_hit;
    result_t     pending_values[$];
    int unsigned mismatches, value_bytes, hits, queries;

    function new();
      key_text   = '0;
      key_length = KEY_LENGTH_RST;
      capacity   = VALUE_CAPACITY_RST;
      mismatches = 0;
      value_bytes = 0;
      hits       = 0;
      queries    = 0;
      restart_query();
    endfunction

    function void write_reg(cfg_index_e idx, logic [63:0] data);
      case (idx)
        CFG_KEY_TEXT:       key_text = data;
        CFG_KEY_LENGTH:     key_length = data[3:0];
        CFG_VALUE_CAPACITY: capacity = data[7:0];
        default: ;
      endcase
    endfunction

    // Clamp the key length into 1..MAX_KEY_CHARS.
    function int unsigned key_chars();
      if (key_length == 0) return 1;
      if (key_length > MAX_KEY_CHARS) return MAX_KEY_CHARS;
      return key_length;
    endfunction

    function void restart_query();
      phase     = PH_MATCH;
      key_pos   = 0;
      raw_count = '0;
      esc       = ESC_NONE;
      hex_hi    = '0;
      key_hit   = 1'b0;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;       // 0-9
      if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;  // a-f
      if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;  // A-F
      return -1;
    endfunction

    function void emit(logic [7:0] c);
      result_t r;
      r.value_byte = c;
      r.byte_valid = 1'b1;
      r.found      = 1'b1;
      r.last       = 1'b0;
      pending_values.push_back(r);
    endfunction

    // A pending escape that never completed goes out literally.
    function void flush_escape();
      if (esc == ESC_PCT) begin
        emit(CHAR_PERCENT);
      end else if (esc == ESC_HEX) begin
        emit(CHAR_PERCENT);
        emit(hex_hi);
      end
      esc = ESC_NONE;
    endfunction

    // Decode one raw value byte; return 1 when a decoded zero closes the value.
    function bit decode_raw(logic [7:0] c);
      int hi, lo;
      if (esc == ESC_PCT) begin
        if (hex_digit(c) >= 0) begin
          hex_hi = c;
          esc = ESC_HEX;
          return 1'b0;
        end
        emit(CHAR_PERCENT);
        esc = ESC_NONE;
      end else if (esc == ESC_HEX) begin
        hi = hex_digit(hex_hi);
        lo = hex_digit(c);
        if (lo >= 0) begin
          esc = ESC_NONE;
          if (hi * 16 + lo == 0) return 1'b1;
          emit(8'(hi * 16 + lo));
          return 1'b0;
        end
        emit(CHAR_PERCENT);
        emit(hex_hi);
        esc = ESC_NONE;
      end
      if (c == CHAR_PERCENT) esc = ESC_PCT;
      else if (c == CHAR_PLUS) emit(CHAR_SPACE);
      else emit(c);
      return 1'b0;
    endfunction

    function void note_item(logic [7:0] c, logic has, logic eoq);
      int unsigned limit;
      result_t     fin;
      limit = (capacity >= 1) ? capacity - 1 : 0;
      if (has) begin
        if (c == CHAR_NUL) begin
          if (phase == PH_VALUE) flush_escape();
          phase = PH_DONE;
        end else begin
          case (phase)
            PH_MATCH: begin
              if (c == CHAR_AMP) begin
                key_pos = 0;
              end else if (key_pos < key_chars()) begin
                if (c == key_text[8*key_pos +: 8]) key_pos++;
                else phase = PH_SKIP;
              end else if (c == CHAR_EQUALS) begin
                key_hit   = 1'b1;
                raw_count = '0;
                esc       = ESC_NONE;
                phase     = (limit == 0) ? PH_DONE : PH_VALUE;
              end else begin
                phase = PH_SKIP;
              end
            end
            PH_SKIP: begin
              if (c == CHAR_AMP) begin
                phase   = PH_MATCH;
                key_pos = 0;
              end
            end
            PH_VALUE: begin
              if (c == CHAR_AMP) begin
                flush_escape();
                phase = PH_DONE;
              end else begin
                raw_count++;
                if (decode_raw(c)) begin
                  phase = PH_DONE;
                end else if (raw_count >= limit) begin
                  flush_escape();
                  phase = PH_DONE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      if (eoq) begin
        if (phase == PH_VALUE) flush_escape();
        fin.value_byte = '0;
        fin.byte_valid = 1'b0;
        fin.found      = key_hit;
        fin.last       = 1'b1;
        pending_values.push_back(fin);
        queries++;
        if (key_hit) hits++;
        restart_query();
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %02h, got %02h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_values.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, got byte %02h valid %b found %b last %b",
                 $time, got.value_byte, got.byte_valid, got.found, got.last);
        return;
      end
      want = pending_values.pop_front();
      compare_field("value_byte", want.value_byte, got.value_byte);
      compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      compare_field("found", 8'(want.found), 8'(got.found));
      compare_field("last", 8'(want.last), 8'(got.last));
      if (got.byte_valid) value_bytes++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  query_byte_i = '0;
  logic        has_byte_i = 1'b0;
  logic        end_of_query_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  value_byte_o;
  logic        byte_valid_o;
  logic        found_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  query_value_checker value_check = new();
  logic [7:0]  qbuf[$];          // query string under construction
  int unsigned items_sent = 0;   // items that carry a byte or end a query
  bit          sender_calm = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned idle_cycles = 0;

  query_param_extract_decode u_top (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Kill the run when no channel moves anything for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding", $time,
                 value_check.pending_values.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: stall randomly before each result, with calm stretches
  // of no stall, and one long hold-off on request to back the block up.
  initial begin
    int unsigned stall, calm_left;
    result_t     got;
    calm_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else if (calm_left > 0) begin
        calm_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 13);
        if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.value_byte = value_byte_o;
      got.byte_valid = byte_valid_o;
      got.found      = found_o;
      got.last       = last_o;
      value_check.check_result(got);
    end
  end

  // Offer one item after a random gap and hold it until it is taken.
  task automatic send_item(logic [7:0] b, logic has, logic eoq);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    query_byte_i   <= b;
    has_byte_i     <= has;
    end_of_query_i <= eoq;
    do @(posedge clk_i); while (!in_ready_o);
    value_check.note_item(b, has, eoq);
    if (has || eoq) items_sent++;
  endtask

  // Send a literal string; the last character optionally ends the query.
  task automatic send_text(string s, bit close = 1'b1);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, close && i == s.len() - 1);
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (value_check.pending_values.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    value_check.write_reg(idx, data);
  endtask

  // Reconfigure only once the block has gone quiet.
  task automatic set_config(logic [63:0] key, logic [3:0] len, logic [7:0] cap);
    drain();
    write_reg(CFG_KEY_TEXT, key);
    write_reg(CFG_KEY_LENGTH, 64'(len));
    write_reg(CFG_VALUE_CAPACITY, 64'(cap));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] pack_key(string s);
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < s.len() && i < 8; i++) k[8*i +: 8] = s[i];
    return k;
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void push_key(int unsigned n);
    for (int unsigned i = 0; i < n; i++) qbuf.push_back(value_check.key_text[8*i +: 8]);
  endfunction

  // Append a raw value: plain text, '+', good and bad escapes, stray bytes.
  function automatic void add_value();
    int unsigned pieces;
    pieces = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 6);
    repeat (pieces) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: qbuf.push_back(pick("abcxyzXYZ0189-._~"));
        8, 9: qbuf.push_back(CHAR_PLUS);
        10, 11, 12, 13: begin
          qbuf.push_back(CHAR_PERCENT);
          qbuf.push_back(pick("0123456789abcdefABCDEF"));
          qbuf.push_back(pick("0123456789abcdefABCDEF"));
        end
        14: begin
          // decoded zero closes the value
          qbuf.push_back(CHAR_PERCENT);
          qbuf.push_back(8'h30);
          qbuf.push_back(8'h30);
        end
        15: begin
          qbuf.push_back(CHAR_PERCENT);
          qbuf.push_back(pick("gGzZ%+=&"));
        end
        16: begin
          qbuf.push_back(CHAR_PERCENT);
          qbuf.push_back(pick("0123456789abcdefABCDEF"));
          qbuf.push_back(pick("gGzZ%+=&"));
        end
        17: qbuf.push_back(8'($urandom_range(1, 255)));
        18: qbuf.push_back(CHAR_PERCENT);
        default: qbuf.push_back(CHAR_EQUALS);
      endcase
    end
  endfunction

  // Segments that resemble the key but must not match it.
  function automatic void add_decoy(int unsigned klen);
    int unsigned cut;
    case ($urandom_range(0, 4))
      0: ;  // empty segment
      1: begin
        cut = $urandom_range(0, klen - 1);
        push_key(cut);
        qbuf.push_back(value_check.key_text[8*cut +: 8] ^ 8'h01);
        qbuf.push_back(CHAR_EQUALS);
        add_value();
      end
      2: begin
        push_key(klen);
        qbuf.push_back(pick("xyz"));
        qbuf.push_back(CHAR_EQUALS);
        add_value();
      end
      3: begin
        push_key(klen);
        repeat ($urandom_range(1, 3)) qbuf.push_back(pick("abcxyz"));
      end
      default: begin
        repeat ($urandom_range(1, 3)) qbuf.push_back(pick("abcdefuvw"));
        qbuf.push_back(CHAR_EQUALS);
        add_value();
      end
    endcase
  endfunction

  // Mostly well-formed queries around the current key, some pure noise.
  function automatic void build_query();
    int unsigned segs, target, klen;
    qbuf.delete();
    klen = value_check.key_chars();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(0, 10)) qbuf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    segs   = $urandom_range(1, 4);
    target = $urandom_range(0, segs);  // segs itself means no matching segment
    for (int unsigned s = 0; s < segs; s++) begin
      if (s > 0) qbuf.push_back(CHAR_AMP);
      if (s == target || $urandom_range(0, 9) == 0) begin
        push_key(klen);
        qbuf.push_back(CHAR_EQUALS);
        add_value();
      end else begin
        add_decoy(klen);
      end
    end
    // Cut the string short with a zero byte and trail some junk.
    if ($urandom_range(0, 7) == 0) begin
      qbuf.push_back(CHAR_NUL);
      repeat ($urandom_range(0, 3)) qbuf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Send the built query, with ignored filler items and sometimes a separate
  // byteless item to close it.
  task automatic send_query();
    bit split_end;
    sender_calm = ($urandom_range(0, 3) == 0);
    split_end   = (qbuf.size() == 0) || ($urandom_range(0, 4) == 0);
    foreach (qbuf[i]) begin
      if ($urandom_range(0, 11) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(qbuf[i], 1'b1, !split_end && i == qbuf.size() - 1);
    end
    if (split_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic run_phase(logic [63:0] key, logic [3:0] len, logic [7:0] cap, bit hold);
    int unsigned stop_at;
    set_config(key, len, cap);
    stop_at = items_sent + PHASE_ITEMS;
    if (hold) long_hold_req = 1'b1;
    while (items_sent < stop_at) begin
      build_query();
      send_query();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty query under the reset configuration.
    send_item(8'h00, 1'b0, 1'b1);
    // Escape, plus, and a percent cut off by the raw byte limit.
    set_config(pack_key("ab"), 4'd2, 8'd6);
    send_text("ab=%41+%z");
    // Decoded zero ends the value.
    send_text("ab=%00");
    // Zero query byte ends the string with an escape half done.
    send_text("ab=%F", 1'b0);
    send_item(CHAR_NUL, 1'b1, 1'b1);
    // Key length zero acts as one; tiny capacity gives only the found flag.
    set_config(pack_key("ab"), 4'd0, 8'd1);
    send_text("a=");

    // Random: sweep key lengths and capacities, extremes included.
    run_phase(pack_key("k"), 4'd1, 8'd255, 1'b1);
    run_phase(pack_key("token123"), 4'd15, 8'd2, 1'b0);
    run_phase(pack_key("ab&c"), 4'd4, 8'd12, 1'b0);
    run_phase(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 8'd16, 1'b0);
    run_phase(pack_key("uid"), 4'd3, 8'd0, 1'b0);
    run_phase(pack_key("q"), 4'd0, 8'd5, 1'b0);
    run_phase(64'h0000_0000_0000_0078, 4'd2, 8'd3, 1'b0);  // key with a zero byte
    drain();

    $display("covered %0d items in %0d queries over ten register settings",
             items_sent, value_check.queries);
    $display("checked %0d decoded value bytes; key found in %0d queries",
             value_check.value_bytes, value_check.hits);
    if (value_check.mismatches == 0 && value_check.pending_values.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
